// ===== rtl/core/pli_pkg.sv =====
// Package for the piecewise linear interpolator: widths, commands, sequencer states.
// No dependencies.
`timescale 1ns / 1ps
package pli_pkg;
	localparam int DEF_MAX_KNOTS = 64;
	localparam int DEF_LANES     = 4;
	localparam int DEF_FRAC_BITS = 16;
	localparam int MAX_LANES     = 4;
	localparam int W             = 32;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_QUERY  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ARD,     // append: read previous knot
		ST_AWAIT,
		ST_ADIV,    // append: serial division in the lanes
		ST_AWR,
		ST_SRCH,    // query: binary search step (read issued)
		ST_SCMP,
		ST_QRD,     // query: read segment data
		ST_QWAIT,
		ST_QMUL,
		ST_QADD,
		ST_OUT
	} state_t;

	// Control from the sequencer to the lanes.
	typedef struct packed {
		logic div_start;
		logic mul_start;
		logic add_start;
		logic inner;
		logic exact;
	} lane_ctl_t;

	typedef struct packed {
		logic signed [W-1:0] pos;
		logic signed [W-1:0] vel;
		logic signed [1:0]   acc;
	} lane_res_t;
endpackage

// ===== rtl/core/pli_lane.sv =====
// One lane: serial slope divider, position multiply/add and slope-change sign.
// Depends on pli_pkg.
`timescale 1ns / 1ps
module pli_lane
	import pli_pkg::*;
#(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lane_ctl_t            ctl,
	input  logic signed [W-1:0]  v_new,
	input  logic signed [W-1:0]  v_prev,
	input  logic [W-1:0]         dt_div,
	input  logic [W:0]           dt_q,
	input  logic signed [W-1:0]  slope_seg,
	input  logic signed [W-1:0]  slope_prv,
	input  logic signed [W-1:0]  v_seg,
	output logic signed [W-1:0]  slope_out,
	output logic                 div_busy,
	output lane_res_t            res
);
	localparam int NW = W + 1 + FRAC_BITS; // dividend magnitude width
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] quo_q;
	logic [W:0]    rem_q;
	logic [W-1:0]  den_q;
	logic          neg_q;
	logic          zero_q;
	logic signed [W:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;

	logic signed [W:0] dv;
	logic [W:0]    dv_mag;
	logic [W+1:0]  trial;

	assign dv     = {v_new[W-1], v_new} - {v_prev[W-1], v_prev};
	assign dv_mag = dv[W] ? (~dv + 1'b1) : dv;
	assign trial  = {rem_q, quo_q[NW-1]} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.div_start) begin
			busy_q <= (dt_div != '0);
			cnt_q  <= CW'(NW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.div_start) begin
			quo_q  <= {dv_mag, {FRAC_BITS{1'b0}}};
			rem_q  <= '0;
			den_q  <= dt_div;
			neg_q  <= dv[W];
			zero_q <= (dt_div == '0);
			dvs_q  <= dv;
		end else if (busy_q) begin
			if (!trial[W+1]) begin
				rem_q <= trial[W:0];
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-1:0], quo_q[NW-1]};
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end
	assign div_busy = busy_q;

	// Saturate the signed quotient.
	localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
	always_comb begin
		if (zero_q)
			slope_out = (dvs_q == '0) ? '0 : (dvs_q[W] ? SMIN : SMAX);
		else if (!neg_q)
			slope_out = (quo_q > NW'(SMAX)) ? SMAX : quo_q[W-1:0];
		else
			slope_out = (quo_q > (NW'(SMAX) + 1'b1)) ? SMIN
				: W'(~quo_q[W-1:0] + 1'b1);
	end

	// Query: product dt * slope, then shift, clamp and add.
	logic signed [2*W+1:0] prod_q;
	logic signed [W-1:0]   vel_q;
	logic signed [W-1:0]   vseg_q;
	logic signed [1:0]     acc_q;
	logic signed [W-1:0]   pos_q;
	logic signed [2*W+1:0] qv;
	logic signed [W+3:0]   qc;
	logic signed [W+4:0]   sum;

	always_comb begin
		if (prod_q[2*W+1])
			qv = -((-prod_q) >>> FRAC_BITS);
		else
			qv = prod_q >>> FRAC_BITS;
		if (qv > (2*W+2)'(64'sd17179869184))
			qc = (W+4)'(64'sd17179869184);
		else if (qv < -(2*W+2)'(64'sd17179869184))
			qc = -(W+4)'(64'sd17179869184);
		else
			qc = qv[W+3:0];
		sum = (W+5)'(vseg_q) + (W+5)'(qc);
	end

	always_ff @(posedge clk) begin
		if (ctl.mul_start) begin
			vel_q  <= ctl.inner ? slope_seg : '0;
			// The time difference is signed: a query before the first knot gives a negative one.
			prod_q <= $signed(dt_q) * $signed(ctl.inner ? slope_seg : '0);
			vseg_q <= v_seg;
			if (ctl.inner && ctl.exact)
				acc_q <= (slope_seg > slope_prv) ? 2'sd1
					: ((slope_seg < slope_prv) ? -2'sd1 : 2'sd0);
			else
				acc_q <= 2'sd0;
		end
		if (ctl.add_start) begin
			if (sum > (W+5)'(SMAX))
				pos_q <= SMAX;
			else if (sum < (W+5)'(SMIN))
				pos_q <= SMIN;
			else
				pos_q <= sum[W-1:0];
		end
	end
	assign res = '{pos: pos_q, vel: vel_q, acc: acc_q};
endmodule

// ===== rtl/core/pli_merge.sv =====
// Output stage: gathers lane results into one registered result word.
// Depends on pli_pkg.
`timescale 1ns / 1ps
module pli_merge
	import pli_pkg::*;
#(
	parameter int LANES = DEF_LANES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  logic                  empty,
	input  lane_res_t             lres [LANES],
	output logic                  busy,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [8*W+7:0]        m_tdata
);
	logic [8*W+7:0] data_q;
	logic [8*W+7:0] data_d;
	logic           vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= 1'b0;
		else if (load)
			vld_q <= 1'b1;
		else if (m_tready)
			vld_q <= 1'b0;
	end
	always_comb begin
		data_d = '0;
		if (!empty)
			for (int i = 0; i < LANES; i++) begin
				data_d[i*W +: W]     = lres[i].pos;
				data_d[(4+i)*W +: W] = lres[i].vel;
				data_d[8*W+2*i +: 2] = lres[i].acc;
			end
	end
	always_ff @(posedge clk) begin
		if (load)
			data_q <= data_d;
	end
	assign m_tvalid = vld_q;
	assign m_tdata  = data_q;
	assign busy     = vld_q;
endmodule

// ===== rtl/core/piecewise_linear_interpolator.sv =====
// Top level of the piecewise linear interpolator: sequencer, knot memories, lanes.
// Depends on pli_pkg, pli_lane and pli_merge.
//
// Channel  Dir  Word contents
// s_axis   in   tuser: cmd; tdata: time_req, value_0..value_3
// m_axis   out  position_0..3, velocity_0..3, accel_sign_0..3 (queries only)
//
// A clear returns straight to idle; an append is paced by the bit-serial slope
// divider in each lane, a query by the binary search over the knot time memory.
// One word is in work at a time; s_tready is low while busy.
// Reset clears the knot count and control; memories need no clearing.
// A stalled result holds in the output register; a new word is not taken
// until the previous result has left.
`timescale 1ns / 1ps
module piecewise_linear_interpolator
	import pli_pkg::*;
#(
	parameter int MAX_KNOTS = DEF_MAX_KNOTS,
	parameter int LANES     = DEF_LANES,
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	// cmd[1:0]
	input  logic [1:0]     s_tuser,
	// time_req[31:0], value_0..value_3[159:32]
	input  logic [159:0]   s_tdata,
	output logic           m_tvalid,
	input  logic           m_tready,
	// position_0..3, velocity_0..3, accel_sign_0..3 (2 bits each) from bit 0
	output logic [8*W+7:0] m_tdata
);
	localparam int AW = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
	localparam int CW = $clog2(MAX_KNOTS + 1);

	state_t st_q, st_d;
	logic [CW-1:0] n_q;
	logic [W-1:0]  t_q;
	logic [W-1:0]  t0_q;
	logic signed [W-1:0] vin_q [LANES];

	logic [W-1:0]  times_mem [MAX_KNOTS];
	logic signed [W-1:0] vals_mem [MAX_KNOTS][LANES];
	logic signed [W-1:0] slp_mem  [MAX_KNOTS][LANES];

	logic [AW-1:0] raddr, lo_q, hi_q, seg_q;
	logic [W-1:0]  trd_q;
	logic signed [W-1:0] vrd_q [LANES];
	logic signed [W-1:0] srd_q [LANES];
	logic signed [W-1:0] sprv_q [LANES];
	logic [W:0]    dtq_q;

	logic accept, out_busy;
	logic [LANES-1:0] dbusy;
	lane_ctl_t ctl;
	lane_res_t lres [LANES];
	logic signed [W-1:0] slope_new [LANES];

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (st_q == ST_IDLE) && !out_busy;

	always_ff @(posedge clk) begin
		if (accept) begin
			t_q   <= s_tdata[31:0];
			for (int i = 0; i < LANES; i++)
				vin_q[i] <= s_tdata[32+i*W +: W];
		end
	end

	// Search step: mid of [lo, hi], upper mid so the largest t_i <= t wins.
	logic [AW:0] mid_w;
	assign mid_w = ({1'b0, lo_q} + {1'b0, hi_q} + 1'b1) >> 1;

	always_comb begin
		raddr = seg_q;
		case (st_q)
			ST_ARD:  raddr = AW'(n_q - 1'b1);
			ST_SRCH: raddr = mid_w[AW-1:0];
			ST_QRD:  raddr = seg_q;
			default: raddr = seg_q;
		endcase
	end

	logic [AW-1:0] prv_addr;
	assign prv_addr = (seg_q == '0) ? '0 : seg_q - 1'b1;
	logic [AW-1:0] waddr;
	assign waddr = n_q[AW-1:0];

	always_ff @(posedge clk) begin
		trd_q <= times_mem[raddr];
		for (int i = 0; i < LANES; i++) begin
			vrd_q[i]  <= vals_mem[raddr][i];
			srd_q[i]  <= slp_mem[raddr][i];
			sprv_q[i] <= slp_mem[prv_addr][i];
		end
		if (st_q == ST_AWR) begin
			times_mem[waddr] <= t_q;
			for (int i = 0; i < LANES; i++) begin
				vals_mem[waddr][i] <= vin_q[i];
				if (n_q != '0)
					slp_mem[AW'(n_q - 1'b1)][i] <= slope_new[i];
			end
		end
	end

	// The first knot's time is kept aside: a query at or before it uses segment 0.
	always_ff @(posedge clk)
		if (st_q == ST_AWR && n_q == '0)
			t0_q <= t_q;

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE:
				if (accept) begin
					case (cmd_t'(s_tuser))
						CMD_APPEND: st_d = ST_ARD;
						CMD_QUERY:  st_d = ST_SRCH;
						default:    st_d = ST_IDLE;
					endcase
				end
			ST_ARD:   st_d = (n_q >= CW'(MAX_KNOTS)) ? ST_IDLE
				: ((n_q == '0) ? ST_AWR : ST_AWAIT);
			ST_AWAIT: st_d = (t_q < trd_q) ? ST_IDLE : ST_ADIV;
			ST_ADIV:  st_d = (dbusy == '0) ? ST_AWR : ST_ADIV;
			ST_AWR:   st_d = ST_IDLE;
			ST_SRCH:  st_d = (n_q == '0) ? ST_OUT : ((lo_q == hi_q) ? ST_QRD : ST_SCMP);
			ST_SCMP:  st_d = ST_SRCH;
			ST_QRD:   st_d = ST_QWAIT;
			ST_QWAIT: st_d = ST_QMUL;
			ST_QMUL:  st_d = ST_QADD;
			ST_QADD:  st_d = ST_OUT;
			ST_OUT:   st_d = ST_IDLE;
			default:  st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			n_q  <= '0;
			lo_q <= '0;
			hi_q <= '0;
			seg_q <= '0;
		end else begin
			st_q <= st_d;
			if (accept && cmd_t'(s_tuser) == CMD_CLEAR)
				n_q <= '0;
			if (st_q == ST_AWR)
				n_q <= n_q + 1'b1;
			if (st_q == ST_IDLE) begin
				lo_q <= '0;
				hi_q <= AW'(n_q - 1'b1);
			end
			if (st_q == ST_SRCH && lo_q == hi_q)
				seg_q <= lo_q;
			if (st_q == ST_SCMP) begin
				// The upper mid was read; keep it if its time is not past t and t lies
				// beyond the first knot.
				if (trd_q <= t_q && t_q > t0_q)
					lo_q <= mid_w[AW-1:0];
				else
					hi_q <= AW'(mid_w - 1'b1);
			end
		end
	end

	// Time difference and lane control. Segment 0 also covers t at or before t_0.
	logic inner, exact;
	logic exact_q;
	assign inner = (CW'(seg_q) + 1'b1) < n_q;
	assign exact = (seg_q != '0) && (t_q == trd_q);
	always_ff @(posedge clk)
		if (st_q == ST_QWAIT)
			dtq_q <= {1'b0, t_q} - {1'b0, trd_q};

	assign ctl.div_start = (st_q == ST_AWAIT) && (t_q >= trd_q);
	assign ctl.mul_start = (st_q == ST_QMUL);
	assign ctl.add_start = (st_q == ST_QADD);
	assign ctl.inner     = inner;
	assign ctl.exact     = exact_q;
	always_ff @(posedge clk)
		if (st_q == ST_QWAIT)
			exact_q <= exact;

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		pli_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.v_new     (vin_q[g]),
			.v_prev    (vrd_q[g]),
			.dt_div    (t_q - trd_q),
			.dt_q      (dtq_q),
			.slope_seg (srd_q[g]),
			.slope_prv (sprv_q[g]),
			.v_seg     (vrd_q[g]),
			.slope_out (slope_new[g]),
			.div_busy  (dbusy[g]),
			.res       (lres[g])
		);
	end

	pli_merge #(.LANES(LANES)) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (st_q == ST_OUT),
		.empty    (n_q == '0),
		.lres     (lres),
		.busy     (out_busy),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CW'(MAX_KNOTS)) else $error("knot count above table size");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_IDLE) |-> !s_tready) else $error("word taken while busy");
	a_search_order: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_SCMP) |-> (lo_q <= hi_q)) else $error("search bounds crossed");
	a_out_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(st_q == ST_OUT)) else $error("result without query");
endmodule
